FILE: rtl/core/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Used by the allocator top level and its port checker; depends on nothing.
package bpa_pkg;

    // Fixed field widths of the stream words and the configuration register.
    localparam int PAGE_W     = 12;
    localparam int ORDER_W    = 4;
    localparam int HEAP_CFG_W = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;

    // Default sizing of the managed heap.
    localparam int HEAP_PAGES_DEF = 4096;
    localparam int NUM_ORDERS_DEF = 13;

    localparam logic [HEAP_CFG_W-1:0] HEAP_CFG_RESET = 13'd4096;

    // Request kinds carried in s_tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status carried in m_tuser.
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

endpackage

FILE: rtl/core/bpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; instantiated by the allocator top level.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/buddy_page_allocator_top.sv
// Buddy page allocator without coalescing: sequencer, per-order stack counts,
// heap cursor and output register. Depends on bpa_pkg and bpa_ram.
//
//  Channel  | Direction | Word contents
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | tuser: operation; tdata: req_order, free_page
//  m_       | out       | tuser: status; tdata: start_page, run_order
//  cfg_wr_  | in        | heap_pages, written on any cycle with cfg_wr_en
//
// One word at a time; s_tready is high only in idle. A free reads the order map and
// pushes the page; a direct pop reads the stack top. A search visits each larger order in
// turn; each split level pushes the buddy and marks its 2^(level-1) pages in the order map,
// then the granted run's 2^req_order pages are marked. A heap bump follows a search that
// visited every larger order and marks the granted run. The order map has one write port.
// Synchronous reset, no clearing pass; a result stalled on m_tready holds the sequencer.
module buddy_page_allocator_top #(
    parameter int HEAP_PAGES = bpa_pkg::HEAP_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: req_order [3:0], free_page [15:4]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpa_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: operation [0]
    input  logic                            s_tuser,
    // m_tdata: start_page [11:0], run_order [15:12]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpa_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: status [0]
    output logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [bpa_pkg::HEAP_CFG_W-1:0]  cfg_wr_data
);

    import bpa_pkg::*;

    localparam int HP_W  = $clog2(HEAP_PAGES);
    localparam int CNT_W = $clog2(HEAP_PAGES + 1);
    localparam int CUR_W = $clog2(HEAP_PAGES + 1);
    localparam int OW    = $clog2(NUM_ORDERS);
    localparam int COW   = $clog2(NUM_ORDERS + 1);
    localparam int M0    = (HP_W > PAGE_W) ? HP_W : PAGE_W;
    localparam int M1    = (M0 > NUM_ORDERS) ? M0 : NUM_ORDERS;
    localparam int PW    = M1 + 2;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DISPATCH  = 13'b0000000000010,
        S_MAP_WAIT  = 13'b0000000000100,
        S_FREE_PUSH = 13'b0000000001000,
        S_POP_CHK   = 13'b0000000010000,
        S_SEARCH    = 13'b0000000100000,
        S_POP_WAIT  = 13'b0000001000000,
        S_SPLIT     = 13'b0000010000000,
        S_BUDDY     = 13'b0000100000000,
        S_SWEEP     = 13'b0001000000000,
        S_ALIGN     = 13'b0010000000000,
        S_BUMP      = 13'b0100000000000,
        S_OUT       = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [ORDER_W-1:0]     ord_reg, ord_next;
    logic [PAGE_W-1:0]      fpage_reg, fpage_next;
    logic [COW-1:0]         cur_ord_reg, cur_ord_next;
    logic [PW-1:0]          page_reg, page_next;
    logic                   status_reg, status_next;
    logic [PW-1:0]          sw_addr_reg, sw_addr_next;
    logic [PW-1:0]          sw_end_reg, sw_end_next;
    logic [OW-1:0]          sw_ord_reg, sw_ord_next;
    logic                   sw_last_reg, sw_last_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [HEAP_CFG_W-1:0]  heap_pages_reg, heap_pages_next;
    logic [CNT_W-1:0]       counts_reg [NUM_ORDERS];
    logic [CNT_W-1:0]       counts_next [NUM_ORDERS];
    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;

    logic [OW-1:0]          cur_idx;
    logic [CNT_W-1:0]       cnt_cur;
    logic [CNT_W-1:0]       cnt_dec;
    logic                   cnt_full;
    logic [PW-1:0]          units_ord;
    logic [PW-1:0]          units_cur;
    logic [PW-1:0]          fpage_ext;
    logic [PW-1:0]          limit;
    logic [PW-1:0]          buddy;
    logic [PW-1:0]          bump_end;
    logic                   sweep_go;
    logic                   out_free;

    logic                   stk_we;
    logic [OW+HP_W-1:0]     stk_waddr;
    logic [PW-1:0]          stk_wdata;
    logic [OW+HP_W-1:0]     stk_raddr;
    logic [PW-1:0]          stk_rdata;
    logic                   map_we;
    logic [OW-1:0]          map_rdata;

    // Per-order free stacks, one region of HEAP_PAGES entries per order.
    bpa_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_ORDERS << HP_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Order recorded for each page.
    bpa_ram #(
        .WIDTH (OW),
        .DEPTH (HEAP_PAGES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (sw_addr_reg[HP_W-1:0]),
        .wdata (sw_ord_reg),
        .raddr (fpage_ext[HP_W-1:0]),
        .rdata (map_rdata)
    );

    // Shared datapath terms: stack depth of the current order and run sizes.
    assign cur_idx   = cur_ord_reg[OW-1:0];
    assign cnt_cur   = counts_reg[cur_idx];
    assign cnt_dec   = cnt_cur - CNT_W'(1);
    assign cnt_full  = (cnt_cur >= CNT_W'(HEAP_PAGES));
    assign units_ord = PW'(1) << ord_reg;
    assign units_cur = PW'(1) << cur_ord_reg;
    assign fpage_ext = PW'(fpage_reg);
    assign buddy     = page_reg + units_cur;
    assign bump_end  = sw_addr_reg + units_ord;
    assign sweep_go  = (sw_addr_reg < sw_end_reg) && (sw_addr_reg < PW'(HEAP_PAGES));
    assign map_we    = (state_reg == S_SWEEP) && sweep_go;
    assign out_free  = !m_valid_reg || m_tready;

    // Usable heap is the configured size capped by the storage size.
    assign limit = (PW'(heap_pages_reg) < PW'(HEAP_PAGES)) ? PW'(heap_pages_reg)
                                                           : PW'(HEAP_PAGES);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ord_next        = ord_reg;
        fpage_next      = fpage_reg;
        cur_ord_next    = cur_ord_reg;
        page_next       = page_reg;
        status_next     = status_reg;
        sw_addr_next    = sw_addr_reg;
        sw_end_next     = sw_end_reg;
        sw_ord_next     = sw_ord_reg;
        sw_last_next    = sw_last_reg;
        cursor_next     = cursor_reg;
        heap_pages_next = cfg_wr_en ? cfg_wr_data : heap_pages_reg;
        counts_next     = counts_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        stk_we          = 1'b0;
        stk_waddr       = {cur_idx, cnt_cur[HP_W-1:0]};
        stk_wdata       = page_reg;
        stk_raddr       = {cur_idx, cnt_dec[HP_W-1:0]};

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    ord_next    = s_tdata[ORDER_W-1:0];
                    fpage_next  = s_tdata[ORDER_W +: PAGE_W];
                    page_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // The map read for a free is issued here with the latched page.
                if (op_reg == OP_FREE) begin
                    page_next  = fpage_ext;
                    state_next = S_MAP_WAIT;
                end else if (int'(ord_reg) >= NUM_ORDERS) begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_OUT;
                end else begin
                    cur_ord_next = COW'(ord_reg);
                    state_next   = S_POP_CHK;
                end
            end
            S_MAP_WAIT: begin
                // Pages outside the store and bad entries count as order zero.
                if ((fpage_ext < PW'(HEAP_PAGES)) && (int'(map_rdata) < NUM_ORDERS)) begin
                    cur_ord_next = COW'(map_rdata);
                end else begin
                    cur_ord_next = '0;
                end
                state_next = S_FREE_PUSH;
            end
            S_FREE_PUSH: begin
                if (cnt_full) begin
                    status_next = ST_NO_SPACE;
                end else begin
                    stk_we               = 1'b1;
                    counts_next[cur_idx] = cnt_cur + CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_POP_CHK: begin
                if (cnt_cur != '0) begin
                    counts_next[cur_idx] = cnt_dec;
                    state_next           = S_POP_WAIT;
                end else begin
                    cur_ord_next = cur_ord_reg + COW'(1);
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Walk up one order per cycle until a nonempty stack is found or the orders run out.
                if (int'(cur_ord_reg) >= NUM_ORDERS) begin
                    sw_addr_next = (PW'(cursor_reg) + units_ord - PW'(1)) &
                                   ~(units_ord - PW'(1));
                    state_next   = S_BUMP;
                end else if (cnt_cur != '0) begin
                    counts_next[cur_idx] = cnt_dec;
                    state_next           = S_POP_WAIT;
                end else begin
                    cur_ord_next = cur_ord_reg + COW'(1);
                end
            end
            S_POP_WAIT: begin
                page_next = stk_rdata;
                if (cur_ord_reg == COW'(ord_reg)) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                cur_ord_next = cur_ord_reg - COW'(1);
                state_next   = S_BUDDY;
            end
            S_BUDDY: begin
                // Push the upper buddy and mark its pages; a full stack drops it.
                if (!cnt_full) begin
                    stk_we               = 1'b1;
                    stk_wdata            = buddy;
                    counts_next[cur_idx] = cnt_cur + CNT_W'(1);
                end
                sw_addr_next = buddy;
                sw_end_next  = buddy + units_cur;
                sw_ord_next  = cur_idx;
                sw_last_next = 1'b0;
                state_next   = S_SWEEP;
            end
            S_SWEEP: begin
                if (sweep_go) begin
                    sw_addr_next = sw_addr_reg + PW'(1);
                end else if (sw_last_reg) begin
                    state_next = S_OUT;
                end else if (cur_ord_reg == COW'(ord_reg)) begin
                    // Split done: mark the granted run itself.
                    sw_addr_next = page_reg;
                    sw_end_next  = page_reg + units_ord;
                    sw_ord_next  = OW'(ord_reg);
                    sw_last_next = 1'b1;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_ALIGN: begin
                state_next = S_BUMP;
            end
            S_BUMP: begin
                // Grant the aligned run at the cursor if it fits the heap.
                if (bump_end > limit) begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_OUT;
                end else begin
                    page_next    = sw_addr_reg;
                    cursor_next  = bump_end[CUR_W-1:0];
                    sw_end_next  = bump_end;
                    sw_ord_next  = OW'(ord_reg);
                    sw_last_next = 1'b1;
                    state_next   = S_SWEEP;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(op_reg == OP_FREE) ? ORDER_W'(cur_ord_reg) : ord_reg,
                                    page_reg[PAGE_W-1:0]};
                    m_user_next  = status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            heap_pages_reg <= HEAP_CFG_RESET;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_ORDERS; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            heap_pages_reg <= heap_pages_next;
            m_valid_reg    <= m_valid_next;
            counts_reg     <= counts_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ord_reg     <= ord_next;
        fpage_reg   <= fpage_next;
        cur_ord_reg <= cur_ord_next;
        page_reg    <= page_next;
        status_reg  <= status_next;
        sw_addr_reg <= sw_addr_next;
        sw_end_reg  <= sw_end_next;
        sw_ord_reg  <= sw_ord_next;
        sw_last_reg <= sw_last_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/bpa_checker.sv
// Port-level checker for the buddy page allocator, bound to its top level.
// Depends on bpa_pkg and buddy_page_allocator_top.
module bpa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bpa_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    // An accepted word keeps the block busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word was still in work");

    // A new result only appears at the end of a busy period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a word in work");

    // A stalled result holds its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
